@@ rtl/bsd_pkg.sv @@
`default_nettype none

package bsd_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    localparam logic [7:0] SIG_FIRST  = 8'h42;
    localparam logic [7:0] SIG_SECOND = 8'h4D;

    localparam logic [31:0] HDR_SIZE_INFO = 32'd40;
    localparam logic [31:0] HDR_SIZE_CORE = 32'd12;
    localparam logic [31:0] HDR_SIZE_OS2  = 32'd64;
    localparam logic [31:0] HDR_SIZE_V4   = 32'd108;
    localparam logic [31:0] HDR_SIZE_V5   = 32'd124;

    localparam logic [31:0] HDR_END_INFO = 32'd54;
    localparam logic [31:0] HDR_END_CORE = 32'd26;

    localparam logic [15:0] BPP_24 = 16'd24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_SKIP,
        PH_PIX,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        TOK_PIXEL_BYTE,
        TOK_HEADER,
        TOK_ERROR
    } tok_kind_t;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_SIGNATURE = 4'd1,
        ERR_OS2V2     = 4'd2,
        ERR_V4        = 4'd3,
        ERR_V5        = 4'd4,
        ERR_UNKNOWN   = 4'd5,
        ERR_BPP       = 4'd6,
        ERR_COMPRESS  = 4'd7,
        ERR_SIZE      = 4'd8,
        ERR_OFFSET    = 4'd9
    } err_t;

    typedef struct packed {
        tok_kind_t   tkind;
        logic [7:0]  data;
        logic [12:0] width;
        logic [12:0] height;
        logic        last;
        err_t        err;
    } token_t;

endpackage

`default_nettype wire

@@ rtl/bmp24_stream_decoder.sv @@
`default_nettype none

// Channel   Ports                                         Transfer when
// input     data_byte, first_byte                         push && !full
// result    kind, red, green, blue, column, row,          pop && !empty
//           last_pixel, image_width, image_height,
//           error_code
//
// One byte is taken every clock while full is low; the parser in the front
// part settles each byte in the cycle it arrives. A result is registered
// first in a four-entry token queue and then, through the pixel assembler,
// in the output register.
// Reset clears all control state at once; there is no clearing pass.
// When pop is held low the output register holds, the queue fills, and full
// rises after four more bytes that produce tokens.

module bmp24_stream_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [11:0]      column,
    output logic [11:0]      row,
    output logic             last_pixel,
    output logic [12:0]      image_width,
    output logic [12:0]      image_height,
    output logic [3:0]       error_code
);

    bsd_pkg::token_t front_tok, head_tok;
    logic front_valid;
    logic accept;
    logic q_full, q_empty, q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    bsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .tok        (front_tok),
        .tok_valid  (front_valid)
    );

    bsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && front_valid),
        .wr_tok  (front_tok),
        .rd_en   (q_pop),
        .rd_tok  (head_tok),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    bsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok          (head_tok),
        .tok_avail    (!q_empty),
        .tok_take     (q_pop),
        .pop          (pop),
        .empty        (empty),
        .kind         (kind),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .column       (column),
        .row          (row),
        .last_pixel   (last_pixel),
        .image_width  (image_width),
        .image_height (image_height),
        .error_code   (error_code)
    );

    // A token is only taken when the output register is free or being emptied.
    a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (empty || pop))
        else $error("token taken while a result waits");

    a_take_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("token taken from an empty queue");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_empty)
        else $error("queue full and empty at once");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == bsd_pkg::KIND_ERROR) |->
            (!last_pixel && red == 8'd0 && image_width == 13'd0))
        else $error("error result carries pixel or header data");

endmodule

`default_nettype wire

@@ rtl/bsd_front.sv @@
`default_nettype none

module bsd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     data_byte,
    input  wire logic           first_byte,
    output bsd_pkg::token_t     tok,
    output logic                tok_valid
);

    bsd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] offset_reg, offset_next;
    logic        short_reg, short_next;
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;

    // State as seen by this byte: a first byte restarts the parser.
    bsd_pkg::phase_t eff_phase;
    logic [31:0] eff_pos, eff_shift, eff_offset;
    logic        eff_short;
    logic [12:0] eff_width, eff_height;

    logic [15:0] fld16;
    logic [31:0] pos_inc;
    bsd_pkg::err_t hdr_err;
    logic        hdr_fin;
    logic [31:0] hdr_end;
    logic        set_offset, set_short_val, set_short, set_width, set_height;
    logic [12:0] new_dim;
    logic        img_empty;

    always_comb
    begin
        if (first_byte)
        begin
            eff_phase  = bsd_pkg::PH_HEAD;
            eff_pos    = '0;
            eff_shift  = '0;
            eff_offset = '0;
            eff_short  = 1'b0;
            eff_width  = '0;
            eff_height = '0;
        end
        else
        begin
            eff_phase  = phase_reg;
            eff_pos    = pos_reg;
            eff_shift  = shift_reg;
            eff_offset = offset_reg;
            eff_short  = short_reg;
            eff_width  = width_reg;
            eff_height = height_reg;
        end
    end

    logic [31:0] shifted;
    assign shifted   = {data_byte, eff_shift[31:8]};
    assign fld16     = shifted[31:16];
    assign pos_inc   = eff_pos + 32'd1;
    assign img_empty = (eff_width == '0) || (eff_height == '0);

    // Header checks; each field on its last byte, signature per byte.
    always_comb
    begin
        hdr_err       = bsd_pkg::ERR_NONE;
        hdr_fin       = 1'b0;
        hdr_end       = bsd_pkg::HDR_END_INFO;
        set_offset    = 1'b0;
        set_short     = 1'b0;
        set_short_val = 1'b0;
        set_width     = 1'b0;
        set_height    = 1'b0;
        new_dim       = '0;
        if (eff_pos == 32'd0 && data_byte != bsd_pkg::SIG_FIRST)
        begin
            hdr_err = bsd_pkg::ERR_SIGNATURE;
        end
        else if (eff_pos == 32'd1 && data_byte != bsd_pkg::SIG_SECOND)
        begin
            hdr_err = bsd_pkg::ERR_SIGNATURE;
        end
        else if (eff_pos == 32'd13)
        begin
            set_offset = 1'b1;
        end
        else if (eff_pos == 32'd17)
        begin
            if (shifted == bsd_pkg::HDR_SIZE_INFO)
            begin
                set_short = 1'b1;
            end
            else if (shifted == bsd_pkg::HDR_SIZE_CORE)
            begin
                set_short     = 1'b1;
                set_short_val = 1'b1;
            end
            else if (shifted == bsd_pkg::HDR_SIZE_OS2)
            begin
                hdr_err = bsd_pkg::ERR_OS2V2;
            end
            else if (shifted == bsd_pkg::HDR_SIZE_V4)
            begin
                hdr_err = bsd_pkg::ERR_V4;
            end
            else if (shifted == bsd_pkg::HDR_SIZE_V5)
            begin
                hdr_err = bsd_pkg::ERR_V5;
            end
            else
            begin
                hdr_err = bsd_pkg::ERR_UNKNOWN;
            end
        end
        else if (!eff_short)
        begin
            if (eff_pos == 32'd21)
            begin
                if (shifted > bsd_pkg::MAX_WIDTH)
                    hdr_err = bsd_pkg::ERR_SIZE;
                else
                begin
                    set_width = 1'b1;
                    new_dim   = shifted[12:0];
                end
            end
            else if (eff_pos == 32'd25)
            begin
                if (shifted > bsd_pkg::MAX_HEIGHT)
                    hdr_err = bsd_pkg::ERR_SIZE;
                else
                begin
                    set_height = 1'b1;
                    new_dim    = shifted[12:0];
                end
            end
            else if (eff_pos == 32'd29)
            begin
                if (fld16 != bsd_pkg::BPP_24)
                    hdr_err = bsd_pkg::ERR_BPP;
            end
            else if (eff_pos == 32'd31)
            begin
                if (fld16 != 16'd0)
                    hdr_err = bsd_pkg::ERR_COMPRESS;
                else
                    hdr_fin = 1'b1;
            end
        end
        else
        begin
            hdr_end = bsd_pkg::HDR_END_CORE;
            if (eff_pos == 32'd19)
            begin
                if (32'(fld16) > bsd_pkg::MAX_WIDTH)
                    hdr_err = bsd_pkg::ERR_SIZE;
                else
                begin
                    set_width = 1'b1;
                    new_dim   = fld16[12:0];
                end
            end
            else if (eff_pos == 32'd21)
            begin
                if (32'(fld16) > bsd_pkg::MAX_HEIGHT)
                    hdr_err = bsd_pkg::ERR_SIZE;
                else
                begin
                    set_height = 1'b1;
                    new_dim    = fld16[12:0];
                end
            end
            else if (eff_pos == 32'd25)
            begin
                if (fld16 != bsd_pkg::BPP_24)
                    hdr_err = bsd_pkg::ERR_BPP;
                else
                    hdr_fin = 1'b1;
            end
        end
        // A data offset inside the header cannot be reached on a stream.
        if (hdr_fin && eff_offset < hdr_end)
        begin
            hdr_fin = 1'b0;
            hdr_err = bsd_pkg::ERR_OFFSET;
        end
    end

    // Next state.
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        offset_next = offset_reg;
        short_next  = short_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (accept)
        begin
            phase_next  = eff_phase;
            pos_next    = eff_pos;
            shift_next  = eff_shift;
            offset_next = eff_offset;
            short_next  = eff_short;
            width_next  = eff_width;
            height_next = eff_height;
            unique case (eff_phase) inside
                bsd_pkg::PH_HEAD:
                begin
                    pos_next   = pos_inc;
                    shift_next = shifted;
                    if (set_offset)
                        offset_next = shifted;
                    if (set_short)
                        short_next = set_short_val;
                    if (set_width)
                        width_next = new_dim;
                    if (set_height)
                        height_next = new_dim;
                    if (hdr_err != bsd_pkg::ERR_NONE)
                        phase_next = bsd_pkg::PH_DONE;
                    else if (hdr_fin)
                    begin
                        if (img_empty)
                            phase_next = bsd_pkg::PH_DONE;
                        else if (pos_inc == eff_offset)
                            phase_next = bsd_pkg::PH_PIX;
                        else
                            phase_next = bsd_pkg::PH_SKIP;
                    end
                end
                bsd_pkg::PH_SKIP:
                begin
                    pos_next = pos_inc;
                    if (pos_inc == eff_offset)
                        phase_next = bsd_pkg::PH_PIX;
                end
                bsd_pkg::PH_PIX:
                begin
                    pos_next = pos_inc;
                end
                bsd_pkg::PH_IDLE, bsd_pkg::PH_DONE:
                begin
                end
                default:
                begin
                    phase_next = bsd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Token toward the back part.
    always_comb
    begin
        tok        = '0;
        tok.tkind  = bsd_pkg::TOK_PIXEL_BYTE;
        tok.data   = data_byte;
        tok.width  = eff_width;
        tok.height = eff_height;
        tok.last   = img_empty;
        tok.err    = hdr_err;
        tok_valid  = 1'b0;
        unique case (eff_phase)
            bsd_pkg::PH_HEAD:
            begin
                if (hdr_err != bsd_pkg::ERR_NONE)
                begin
                    tok.tkind = bsd_pkg::TOK_ERROR;
                    tok_valid = 1'b1;
                end
                else if (hdr_fin)
                begin
                    tok.tkind = bsd_pkg::TOK_HEADER;
                    tok_valid = 1'b1;
                end
            end
            bsd_pkg::PH_PIX:
            begin
                tok_valid = 1'b1;
            end
            default:
            begin
                tok_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bsd_pkg::PH_IDLE;
            pos_reg    <= '0;
            shift_reg  <= '0;
            offset_reg <= '0;
            short_reg  <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            offset_reg <= offset_next;
            short_reg  <= short_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bsd_queue.sv @@
`default_nettype none

module bsd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire bsd_pkg::token_t   wr_tok,
    input  wire logic              rd_en,
    output bsd_pkg::token_t        rd_tok,
    output logic                   q_full,
    output logic                   q_empty
);

    bsd_pkg::token_t slot_reg [bsd_pkg::QUEUE_DEPTH];
    logic [bsd_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bsd_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bsd_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic do_wr, do_rd;

    assign q_full  = (count_reg == (bsd_pkg::QUEUE_AW+1)'(bsd_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_tok  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == bsd_pkg::QUEUE_AW'(bsd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + bsd_pkg::QUEUE_AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == bsd_pkg::QUEUE_AW'(bsd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + bsd_pkg::QUEUE_AW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + (bsd_pkg::QUEUE_AW+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (bsd_pkg::QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_tok;
    end

endmodule

`default_nettype wire

@@ rtl/bsd_back.sv @@
`default_nettype none

module bsd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bsd_pkg::token_t   tok,
    input  wire logic              tok_avail,
    output logic                   tok_take,
    input  wire logic              pop,
    output logic                   empty,
    output logic [1:0]             kind,
    output logic [7:0]             red,
    output logic [7:0]             green,
    output logic [7:0]             blue,
    output logic [11:0]            column,
    output logic [11:0]            row,
    output logic                   last_pixel,
    output logic [12:0]            image_width,
    output logic [12:0]            image_height,
    output logic [3:0]             error_code
);

    logic        active_reg, active_next;
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic [13:0] w3_reg, w3_next;
    logic [13:0] stride_reg, stride_next;
    logic [11:0] col_reg, col_next;
    logic [12:0] row_cnt_reg, row_cnt_next;
    logic [13:0] rbc_reg, rbc_next;
    logic [1:0]  chan_reg, chan_next;
    logic [7:0]  held_blue_reg, held_blue_next;
    logic [7:0]  held_green_reg, held_green_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [11:0] column_reg, column_next, row_reg, row_next;
    logic        last_reg, last_next;
    logic [12:0] iw_reg, iw_next, ih_reg, ih_next;
    logic [3:0]  err_reg, err_next;

    logic        emit;
    logic [13:0] tok_w3;
    logic [13:0] rbc_inc;
    logic [12:0] row_inc;

    assign tok_take = tok_avail && (!out_valid_reg || pop);
    assign tok_w3   = {tok.width, 1'b0} + {1'b0, tok.width};
    assign rbc_inc  = rbc_reg + 14'd1;
    assign row_inc  = row_cnt_reg + 13'd1;

    always_comb
    begin
        active_next     = active_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        w3_next         = w3_reg;
        stride_next     = stride_reg;
        col_next        = col_reg;
        row_cnt_next    = row_cnt_reg;
        rbc_next        = rbc_reg;
        chan_next       = chan_reg;
        held_blue_next  = held_blue_reg;
        held_green_next = held_green_reg;
        emit            = 1'b0;
        kind_next       = kind_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        last_next       = last_reg;
        iw_next         = iw_reg;
        ih_next         = ih_reg;
        err_next        = err_reg;
        if (tok_take)
        begin
            unique case (tok.tkind)
                bsd_pkg::TOK_HEADER:
                begin
                    active_next  = !tok.last;
                    width_next   = tok.width;
                    height_next  = tok.height;
                    w3_next      = tok_w3;
                    stride_next  = (tok_w3 + 14'd3) & ~14'd3;
                    col_next     = '0;
                    row_cnt_next = '0;
                    rbc_next     = '0;
                    chan_next    = '0;
                    emit         = 1'b1;
                    kind_next    = bsd_pkg::KIND_HEADER;
                    red_next     = '0;
                    green_next   = '0;
                    blue_next    = '0;
                    column_next  = '0;
                    row_next     = '0;
                    last_next    = tok.last;
                    iw_next      = tok.width;
                    ih_next      = tok.height;
                    err_next     = bsd_pkg::ERR_NONE;
                end
                bsd_pkg::TOK_ERROR:
                begin
                    active_next = 1'b0;
                    emit        = 1'b1;
                    kind_next   = bsd_pkg::KIND_ERROR;
                    red_next    = '0;
                    green_next  = '0;
                    blue_next   = '0;
                    column_next = '0;
                    row_next    = '0;
                    last_next   = 1'b0;
                    iw_next     = '0;
                    ih_next     = '0;
                    err_next    = tok.err;
                end
                bsd_pkg::TOK_PIXEL_BYTE:
                begin
                    if (active_reg)
                    begin
                        if (rbc_reg < w3_reg)
                        begin
                            if (chan_reg == 2'd0)
                            begin
                                held_blue_next = tok.data;
                                chan_next      = 2'd1;
                            end
                            else if (chan_reg == 2'd1)
                            begin
                                held_green_next = tok.data;
                                chan_next       = 2'd2;
                            end
                            else
                            begin
                                emit        = 1'b1;
                                kind_next   = bsd_pkg::KIND_PIXEL;
                                red_next    = tok.data;
                                green_next  = held_green_reg;
                                blue_next   = held_blue_reg;
                                column_next = col_reg;
                                row_next    = row_cnt_reg[11:0];
                                last_next   = ({1'b0, col_reg} + 13'd1 == width_reg)
                                           && (row_inc == height_reg);
                                iw_next     = '0;
                                ih_next     = '0;
                                err_next    = bsd_pkg::ERR_NONE;
                                col_next    = col_reg + 12'd1;
                                chan_next   = 2'd0;
                            end
                        end
                        // Padding bytes fall through here and only advance the count.
                        rbc_next = rbc_inc;
                        if (rbc_inc >= stride_reg)
                        begin
                            rbc_next     = '0;
                            col_next     = '0;
                            chan_next    = '0;
                            row_cnt_next = row_inc;
                            if (row_inc >= height_reg)
                                active_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_cnt_reg   <= '0;
            rbc_reg       <= '0;
            chan_reg      <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_cnt_reg   <= row_cnt_next;
            rbc_reg       <= rbc_next;
            chan_reg      <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg      <= width_next;
        height_reg     <= height_next;
        w3_reg         <= w3_next;
        stride_reg     <= stride_next;
        held_blue_reg  <= held_blue_next;
        held_green_reg <= held_green_next;
        kind_reg       <= kind_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
        column_reg     <= column_next;
        row_reg        <= row_next;
        last_reg       <= last_next;
        iw_reg         <= iw_next;
        ih_reg         <= ih_next;
        err_reg        <= err_next;
    end

    assign empty        = !out_valid_reg;
    assign kind         = kind_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign column       = column_reg;
    assign row          = row_reg;
    assign last_pixel   = last_reg;
    assign image_width  = iw_reg;
    assign image_height = ih_reg;
    assign error_code   = err_reg;

endmodule

`default_nettype wire

@@ tb/sv/bmp24_result_checker.sv @@
`timescale 1ns / 100ps

module bmp24_result_checker
    import bsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  kind,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [11:0] column,
    input  logic [11:0] row,
    input  logic        last_pixel,
    input  logic [12:0] image_width,
    input  logic [12:0] image_height,
    input  logic [3:0]  error_code,
    output int          fail_count,
    output int          results_pending
);

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
        logic [12:0] width;
        logic [12:0] height;
        err_t        err;
    } bmp_result_t;

    bmp_result_t predicted[$];
    int          mismatch_total;

    // Decoder state; counters and header fields kept 32 bits wide so the row
    // counter can step past the image height without wrapping.
    phase_t      phase;
    logic [31:0] byte_pos;
    logic [31:0] hdr_shift;
    logic [31:0] data_offset;
    logic        core_hdr;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [31:0] col_cnt;
    logic [31:0] row_cnt;
    logic [31:0] row_bytes;
    logic [7:0]  held_b;
    logic [7:0]  held_g;

    task automatic clear_decoder();
        phase       = PH_IDLE;
        byte_pos    = '0;
        hdr_shift   = '0;
        data_offset = '0;
        core_hdr    = 1'b0;
        img_w       = '0;
        img_h       = '0;
        col_cnt     = '0;
        row_cnt     = '0;
        row_bytes   = '0;
        held_b      = '0;
        held_g      = '0;
    endtask

    task automatic raise_error(input err_t code);
        bmp_result_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.err = code;
        phase = PH_DONE;
        predicted.push_back(r);
    endtask

    task automatic close_header(input logic [31:0] pos, input logic [31:0] hdr_end);
        bmp_result_t r;
        logic        empty_img;
        if (data_offset < hdr_end) begin
            // The pixel data would start inside bytes already consumed.
            raise_error(ERR_OFFSET);
        end
        else begin
            empty_img = (img_w == 0) || (img_h == 0);
            col_cnt = '0;
            row_cnt = '0;
            row_bytes = '0;
            if (empty_img)
                phase = PH_DONE;
            else if (pos + 1 == data_offset)
                phase = PH_PIX;
            else
                phase = PH_SKIP;
            r = '0;
            r.kind = KIND_HEADER;
            r.last = empty_img;
            r.width = img_w[12:0];
            r.height = img_h[12:0];
            predicted.push_back(r);
        end
    endtask

    task automatic parse_header(input logic [7:0] b, input logic [31:0] pos);
        logic [31:0] v16;
        hdr_shift = {b, hdr_shift[31:8]};
        v16 = {16'h0, hdr_shift[31:16]};
        if (pos == 0 && b != SIG_FIRST)
            raise_error(ERR_SIGNATURE);
        else if (pos == 1 && b != SIG_SECOND)
            raise_error(ERR_SIGNATURE);
        else if (pos == 13)
            data_offset = hdr_shift;
        else if (pos == 17) begin
            case (hdr_shift)
                HDR_SIZE_INFO: core_hdr = 1'b0;
                HDR_SIZE_CORE: core_hdr = 1'b1;
                HDR_SIZE_OS2:  raise_error(ERR_OS2V2);
                HDR_SIZE_V4:   raise_error(ERR_V4);
                HDR_SIZE_V5:   raise_error(ERR_V5);
                default:       raise_error(ERR_UNKNOWN);
            endcase
        end
        else if (pos >= 18 && !core_hdr) begin
            if (pos == 21) begin
                if (hdr_shift > MAX_WIDTH) raise_error(ERR_SIZE);
                else img_w = hdr_shift;
            end
            else if (pos == 25) begin
                if (hdr_shift > MAX_HEIGHT) raise_error(ERR_SIZE);
                else img_h = hdr_shift;
            end
            else if (pos == 29) begin
                if (hdr_shift[31:16] != BPP_24) raise_error(ERR_BPP);
            end
            else if (pos == 31) begin
                if (hdr_shift[31:16] != 16'h0) raise_error(ERR_COMPRESS);
                else close_header(pos, HDR_END_INFO);
            end
        end
        else if (pos >= 18) begin
            if (pos == 19) begin
                if (v16 > MAX_WIDTH) raise_error(ERR_SIZE);
                else img_w = v16;
            end
            else if (pos == 21) begin
                if (v16 > MAX_HEIGHT) raise_error(ERR_SIZE);
                else img_h = v16;
            end
            else if (pos == 25) begin
                if (v16[15:0] != BPP_24) raise_error(ERR_BPP);
                else close_header(pos, HDR_END_CORE);
            end
        end
    endtask

    task automatic assemble_pixel(input logic [7:0] b);
        logic [31:0] stride;
        logic [31:0] chan;
        bmp_result_t r;
        stride = ((img_w * 3 + 3) / 4) * 4;
        if (row_bytes < img_w * 3) begin
            chan = row_bytes - 3 * col_cnt;
            if (chan == 0)
                held_b = b;
            else if (chan == 1)
                held_g = b;
            else begin
                r = '0;
                r.kind = KIND_PIXEL;
                r.red = b;
                r.green = held_g;
                r.blue = held_b;
                r.column = col_cnt[11:0];
                r.row = row_cnt[11:0];
                r.last = (col_cnt + 1 == img_w) && (row_cnt + 1 == img_h);
                predicted.push_back(r);
                col_cnt = col_cnt + 1;
            end
        end
        // Bytes past width*3 are row padding and only advance the count.
        row_bytes = row_bytes + 1;
        if (row_bytes >= stride) begin
            row_bytes = '0;
            col_cnt = '0;
            row_cnt = row_cnt + 1;
            if (row_cnt >= img_h)
                phase = PH_DONE;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic restart);
        logic [31:0] pos;
        logic        active;
        if (restart) begin
            clear_decoder();
            phase = PH_HEAD;
        end
        pos = byte_pos;
        active = (phase == PH_HEAD) || (phase == PH_SKIP) || (phase == PH_PIX);
        case (phase)
            PH_HEAD: parse_header(b, pos);
            PH_SKIP: if (pos + 1 == data_offset) phase = PH_PIX;
            PH_PIX:  assemble_pixel(b);
            default: ;
        endcase
        if (active)
            byte_pos = pos + 1;
    endtask

    task automatic check_field(input string label, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want_v, got_v);
            mismatch_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        bmp_result_t want;
        if (!rst_n) begin
            clear_decoder();
            predicted.delete();
            mismatch_total = 0;
            fail_count <= 0;
            results_pending <= 0;
        end
        else begin
            if (push && !full)
                decode_byte(data_byte, first_byte);
            if (pop && !empty) begin
                if (predicted.size() == 0) begin
                    $display("%0t: result expected none, got kind %0d", $time, kind);
                    mismatch_total++;
                end
                else begin
                    want = predicted.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                    check_field("column", want.column, column);
                    check_field("row", want.row, row);
                    check_field("last_pixel", want.last, last_pixel);
                    check_field("image_width", want.width, image_width);
                    check_field("image_height", want.height, image_height);
                    check_field("error_code", want.err, error_code);
                end
            end
            fail_count <= mismatch_total;
            results_pending <= predicted.size();
        end
    end

endmodule

@@ tb/sv/bmp24_stream_decoder_tb.sv @@
`timescale 1ns / 100ps

module bmp24_stream_decoder_tb;

    import bsd_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 2;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BYTES   = 200;
    localparam int DRAIN_CYCLES   = 16;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [3:0]  error_code;
    int          fail_count;
    int          results_pending;

    logic [7:0]  file_bytes[$];
    logic        send_burst;
    logic        take_burst;
    int          bytes_sent;
    int          results_taken;
    logic        held_off;

    bmp24_stream_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .column       (column),
        .row          (row),
        .last_pixel   (last_pixel),
        .image_width  (image_width),
        .image_height (image_height),
        .error_code   (error_code)
    );

    bmp24_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .data_byte       (data_byte),
        .first_byte      (first_byte),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .column          (column),
        .row             (row),
        .last_pixel      (last_pixel),
        .image_width     (image_width),
        .image_height    (image_height),
        .error_code      (error_code),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic send_byte(input logic [7:0] b, input logic restart);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        first_byte <= restart;
        @(posedge clk);
        while (full) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        send_burst = ($urandom_range(0, 3) == 0);
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == 0);
    endtask

    task automatic put_le(input int at, input logic [31:0] val, input int nbytes);
        for (int k = 0; k < nbytes; k++)
            file_bytes[at + k] = val[8 * k +: 8];
    endtask

    // Builds a file with random filler in every field the decoder skips.
    task automatic build_bmp(input logic [31:0] hsize, input logic [31:0] w,
                             input logic [31:0] h, input logic [15:0] bpp,
                             input logic [15:0] comp, input logic [31:0] offset,
                             input int body);
        int hdr_end;
        hdr_end = (hsize == HDR_SIZE_CORE) ? 26 : 54;
        file_bytes.delete();
        for (int i = 0; i < hdr_end; i++)
            file_bytes.push_back(8'($urandom));
        file_bytes[0] = SIG_FIRST;
        file_bytes[1] = SIG_SECOND;
        put_le(10, offset, 4);
        put_le(14, hsize, 4);
        if (hsize == HDR_SIZE_CORE) begin
            put_le(18, w, 2);
            put_le(20, h, 2);
            put_le(24, {16'h0, bpp}, 2);
        end
        else begin
            put_le(18, w, 4);
            put_le(22, h, 4);
            put_le(28, {16'h0, bpp}, 2);
            put_le(30, {16'h0, comp}, 2);
        end
        while (file_bytes.size() < offset && file_bytes.size() < hdr_end + 64)
            file_bytes.push_back(8'($urandom));
        for (int i = 0; i < body; i++)
            file_bytes.push_back(8'($urandom));
    endtask

    function automatic int image_bytes(input int w, input int h);
        return ((w * 3 + 3) / 4) * 4 * h;
    endfunction

    task automatic directed_files();
        // Bytes before any file start are dropped.
        send_burst = 1'b0;
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        build_bmp(HDR_SIZE_INFO, 2, 2, BPP_24, 0, 54, image_bytes(2, 2) + 2);
        send_file();
        build_bmp(HDR_SIZE_CORE, 3, 1, BPP_24, 0, 26, image_bytes(3, 1));
        send_file();
        build_bmp(HDR_SIZE_CORE, 1, 2, BPP_24, 0, 30, image_bytes(1, 2));
        send_file();
        build_bmp(HDR_SIZE_INFO, 1, 1, BPP_24, 0, 54, 3);
        file_bytes[0] = 8'h58;
        send_file();
        build_bmp(HDR_SIZE_INFO, 1, 1, BPP_24, 0, 54, 3);
        file_bytes[1] = SIG_FIRST;
        send_file();
        build_bmp(HDR_SIZE_OS2, 1, 1, BPP_24, 0, 54, 2);
        send_file();
        build_bmp(HDR_SIZE_V4, 1, 1, BPP_24, 0, 54, 2);
        send_file();
        build_bmp(HDR_SIZE_V5, 1, 1, BPP_24, 0, 54, 2);
        send_file();
        build_bmp(32'h0, 1, 1, BPP_24, 0, 54, 0);
        send_file();
        build_bmp(32'hFFFF_FFFF, 1, 1, BPP_24, 0, 54, 0);
        send_file();
        build_bmp(HDR_SIZE_INFO, 1, 1, 16'd32, 0, 54, 3);
        send_file();
        build_bmp(HDR_SIZE_INFO, 1, 1, BPP_24, 16'h8001, 54, 3);
        send_file();
        build_bmp(HDR_SIZE_INFO, MAX_WIDTH + 1, 1, BPP_24, 0, 54, 0);
        send_file();
        build_bmp(HDR_SIZE_INFO, 32'hFFFF_FFFF, 1, BPP_24, 0, 54, 0);
        send_file();
        build_bmp(HDR_SIZE_INFO, 1, 32'h8000_0000, BPP_24, 0, 54, 0);
        send_file();
        build_bmp(HDR_SIZE_CORE, MAX_WIDTH + 1, 1, BPP_24, 0, 26, 0);
        send_file();
        build_bmp(HDR_SIZE_CORE, 1, 16'hFFFF, BPP_24, 0, 26, 0);
        send_file();
        build_bmp(HDR_SIZE_CORE, 1, 1, 16'hFFFF, 0, 26, 3);
        send_file();
        build_bmp(HDR_SIZE_INFO, 1, 1, BPP_24, 0, 53, 3);
        send_file();
        build_bmp(HDR_SIZE_CORE, 1, 1, BPP_24, 0, 25, 3);
        send_file();
        // Empty images: the header result carries last_pixel and the rest is dropped.
        build_bmp(HDR_SIZE_INFO, 0, 3, BPP_24, 0, 54, 6);
        send_file();
        build_bmp(HDR_SIZE_CORE, 2, 0, BPP_24, 0, 26, 6);
        send_file();
        // Largest legal sizes, cut short by the next file.
        build_bmp(HDR_SIZE_INFO, MAX_WIDTH, 1, BPP_24, 0, 54, 30);
        send_file();
        build_bmp(HDR_SIZE_CORE, 1, MAX_HEIGHT, BPP_24, 0, 26, 20);
        send_file();
        build_bmp(HDR_SIZE_INFO, 1, 1, BPP_24, 0, 32'hFFFF_FFF0, 8);
        send_file();
    endtask

    task automatic random_file();
        int          sel;
        int          hdr_end;
        int          body;
        logic [31:0] hs;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] off;
        logic [15:0] bpp;
        logic [15:0] comp;
        logic        bad_sig;
        sel = $urandom_range(0, 19);
        hs = $urandom_range(0, 1) ? HDR_SIZE_INFO : HDR_SIZE_CORE;
        hdr_end = (hs == HDR_SIZE_CORE) ? 26 : 54;
        w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
        h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
        off = hdr_end + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
        bpp = BPP_24;
        comp = 16'h0;
        bad_sig = 1'b0;
        body = image_bytes(w, h) + $urandom_range(0, 3);
        if (sel >= 13 && sel < 15) begin
            body = $urandom_range(0, body);
        end
        else if (sel >= 15 && sel < 18) begin
            body = $urandom_range(0, 6);
            case ($urandom_range(0, 5))
                0: begin
                    case ($urandom_range(0, 3))
                        0: hs = HDR_SIZE_OS2;
                        1: hs = HDR_SIZE_V4;
                        2: hs = HDR_SIZE_V5;
                        default: hs = $urandom;
                    endcase
                end
                1: bpp = 16'($urandom_range(0, 1) ? $urandom_range(0, 23)
                                                 : $urandom_range(25, 65535));
                2: comp = 16'($urandom_range(1, 65535));
                3: begin
                    if ($urandom_range(0, 1))
                        w = $urandom_range(MAX_WIDTH + 1, 65535);
                    else
                        h = $urandom_range(MAX_HEIGHT + 1, 65535);
                end
                4: off = $urandom_range(0, hdr_end - 1);
                default: bad_sig = 1'b1;
            endcase
        end
        if (sel >= 18) begin
            // Stray bytes, then a file of random content.
            send_burst = 1'b0;
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
            file_bytes.delete();
            repeat ($urandom_range(10, 30)) file_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 1)) begin
                file_bytes[0] = SIG_FIRST;
                file_bytes[1] = SIG_SECOND;
            end
        end
        else begin
            build_bmp(hs, w, h, bpp, comp, off, body);
            if (bad_sig)
                file_bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        end
        send_file();
    endtask

    // Result side: random pauses, one long hold-off so the block fills up.
    initial begin
        int gap;
        pop = 1'b0;
        take_burst = 1'b0;
        held_off = 1'b0;
        results_taken = 0;
        wait (rst_n);
        forever begin
            gap = take_burst ? 0 : $urandom_range(0, 7);
            if (!held_off && results_taken == HOLD_AT_RESULT) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            else if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            results_taken++;
            if (results_taken % 50 == 0)
                take_burst = ($urandom_range(0, 2) == 0);
        end
    end

    // A transfer on either side restarts the stall count.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("bmp24_stream_decoder regression: fail");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        push = 1'b0;
        data_byte = 8'h00;
        first_byte = 1'b0;
        send_burst = 1'b0;
        bytes_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_files();
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
            random_file();
        push <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("bmp24_stream_decoder regression: pass");
        else
            $display("bmp24_stream_decoder regression: fail");
        $finish;
    end

endmodule

@@ bmp24_stream_decoder.f @@
rtl/bsd_pkg.sv
rtl/bsd_front.sv
rtl/bsd_queue.sv
rtl/bsd_back.sv
rtl/bmp24_stream_decoder.sv
tb/sv/bmp24_result_checker.sv
tb/sv/bmp24_stream_decoder_tb.sv
